// ===== hdl/layer_thickness_map_blend_defines.svh =====
// ----------------------------------------------------------------------------
// Layer thickness map blend - assertion macros
// Shared concurrent assertion helpers for the map blend RTL.
// ----------------------------------------------------------------------------
`ifndef LAYER_THICKNESS_MAP_BLEND_DEFINES_SVH
`define LAYER_THICKNESS_MAP_BLEND_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LTMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ltmb assertion failed");
// next-cycle implication
`define LTMB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ltmb assertion failed");
`else
`define LTMB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LTMB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/ltmb_pkg.sv =====
// ----------------------------------------------------------------------------
// ltmb_pkg
// Types and constants shared by the layer thickness map blend modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ltmb_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_ROWS   = 256;
	localparam int COL_BITS   = $clog2(MAX_COLS);
	localparam int ROW_BITS   = $clog2(MAX_ROWS);
	localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
	localparam int TBL_DEPTH  = MAX_COLS * MAX_ROWS;

	// table entry: {valid, signed Q11.5 thickness}
	localparam int H_W        = 17;
	localparam int ENTRY_W    = H_W + 1;

	localparam int DIST_W     = 16;
	localparam int VAL_W      = 16;
	localparam int OUT_W      = 24;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
	localparam int ROUND_HALF = 128;

	localparam int DIV_STAGES = VAL_W;
	localparam int LEN_W      = DIST_W + 1;
	localparam int NUM_W      = VAL_W + LEN_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_BLEND_MODE   = 2'd0,
		REG_SCALE_FACTOR = 2'd1,
		REG_COLS_IN_USE  = 2'd2,
		REG_ROWS_IN_USE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic        blend_mode;
		logic [15:0] scale_factor;
		logic [10:0] cols_in_use;
		logic [8:0]  rows_in_use;
	} cfg_t;

	// one classified query word between front and back
	typedef struct packed {
		logic              vis;
		logic              blend;
		logic [VAL_W-1:0]  h1;
		logic [VAL_W-1:0]  h2;
		logic [DIST_W-1:0] near_dist;
		logic [DIST_W-1:0] far_dist;
	} job_t;

endpackage

// ===== hdl/ltmb_ram.sv =====
// ----------------------------------------------------------------------------
// ltmb_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== hdl/ltmb_front.sv =====
// ----------------------------------------------------------------------------
// ltmb_front
// Takes items, writes loads into the table, reads both entries for queries
// and classifies them into queue words. Clears the table after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "layer_thickness_map_blend_defines.svh"

module ltmb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  ltmb_pkg::cfg_t      cfg,
	input  logic                action,
	input  logic [15:0]         first_boundary,
	input  logic                first_boundary_valid,
	input  logic [15:0]         second_boundary,
	input  logic                second_boundary_valid,
	input  logic                pixel_known,
	input  logic [9:0]          near_col,
	input  logic [9:0]          near_row,
	input  logic [15:0]         near_dist,
	input  logic [9:0]          far_col,
	input  logic [9:0]          far_row,
	input  logic [15:0]         far_dist,
	output logic                clearing,
	output logic                push,
	output ltmb_pkg::job_t      job
);

	logic        valid_s1, action_s1, b1v_s1, b2v_s1, known_s1;
	logic [15:0] b1_s1, b2_s1, nd_s1, fd_s1;
	logic [9:0]  ncol_s1, nrow_s1, fcol_s1, frow_s1;

	logic        valid_s2, action_s2, known_s2, near_ok_s2, far_ok_s2;
	logic [15:0] nd_s2, fd_s2;

	logic                           clear_q;
	logic [ltmb_pkg::ADDR_BITS-1:0] clr_addr_q;

	logic                            near_in, far_in, in_table, we;
	logic [ltmb_pkg::ADDR_BITS-1:0]  near_addr, far_addr, waddr;
	logic [ltmb_pkg::ENTRY_W-1:0]    wdata, near_e, far_e;
	logic [ltmb_pkg::H_W-1:0]        diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (clear_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ltmb_pkg::ADDR_BITS'(ltmb_pkg::TBL_DEPTH - 1)) begin
					clear_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			b1_s1     <= first_boundary;
			b1v_s1    <= first_boundary_valid;
			b2_s1     <= second_boundary;
			b2v_s1    <= second_boundary_valid;
			known_s1  <= pixel_known;
			ncol_s1   <= near_col;
			nrow_s1   <= near_row;
			nd_s1     <= near_dist;
			fcol_s1   <= far_col;
			frow_s1   <= far_row;
			fd_s1     <= far_dist;
		end
		action_s2  <= action_s1;
		known_s2   <= known_s1;
		near_ok_s2 <= near_in;
		far_ok_s2  <= far_in;
		nd_s2      <= nd_s1;
		fd_s2      <= fd_s1;
	end

	// area in use is the smaller of the configured size and the table size
	always_comb begin
		near_in = (32'(ncol_s1) < 32'(cfg.cols_in_use)) && (32'(ncol_s1) < ltmb_pkg::MAX_COLS)
			&& (32'(nrow_s1) < 32'(cfg.rows_in_use)) && (32'(nrow_s1) < ltmb_pkg::MAX_ROWS);
		far_in = (32'(fcol_s1) < 32'(cfg.cols_in_use)) && (32'(fcol_s1) < ltmb_pkg::MAX_COLS)
			&& (32'(frow_s1) < 32'(cfg.rows_in_use)) && (32'(frow_s1) < ltmb_pkg::MAX_ROWS);
		in_table = (32'(ncol_s1) < ltmb_pkg::MAX_COLS) && (32'(nrow_s1) < ltmb_pkg::MAX_ROWS);
		near_addr = {ltmb_pkg::ROW_BITS'(nrow_s1), ltmb_pkg::COL_BITS'(ncol_s1)};
		far_addr  = {ltmb_pkg::ROW_BITS'(frow_s1), ltmb_pkg::COL_BITS'(fcol_s1)};
		diff = {1'b0, b2_s1} - {1'b0, b1_s1};
		if (clear_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = valid_s1 && (action_s1 == ltmb_pkg::ACT_LOAD) && in_table;
			waddr = near_addr;
			wdata = (b1v_s1 && b2v_s1) ? {1'b1, diff} : '0;
		end
	end

	ltmb_ram #(
		.WIDTH(ltmb_pkg::ENTRY_W),
		.DEPTH(ltmb_pkg::TBL_DEPTH)
	) u_table (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(near_addr),
		.rdata_a(near_e),
		.raddr_b(far_addr),
		.rdata_b(far_e)
	);

	// entry MSB is the valid flag, next bit the thickness sign
	always_comb begin
		job.vis = known_s2 && near_ok_s2 && near_e[ltmb_pkg::ENTRY_W-1]
			&& !near_e[ltmb_pkg::H_W-1];
		job.blend = cfg.blend_mode && (nd_s2 != '0) && far_ok_s2
			&& far_e[ltmb_pkg::ENTRY_W-1] && !far_e[ltmb_pkg::H_W-1];
		job.h1        = near_e[ltmb_pkg::VAL_W-1:0];
		job.h2        = far_e[ltmb_pkg::VAL_W-1:0];
		job.near_dist = nd_s2;
		job.far_dist  = fd_s2;
	end

	assign push     = valid_s2 && (action_s2 == ltmb_pkg::ACT_QUERY);
	assign clearing = clear_q;

	`LTMB_ASSERT_IMP(a_no_item_in_clear, clk, arst_n, clear_q, !valid_s1)

endmodule

// ===== hdl/ltmb_queue.sv =====
// ----------------------------------------------------------------------------
// ltmb_queue
// Short FIFO of classified query words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "layer_thickness_map_blend_defines.svh"

module ltmb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ltmb_pkg::job_t push_job,
	input  logic           pop,
	output ltmb_pkg::job_t pop_job,
	output logic           not_empty,
	output logic           nearly_full
);

	ltmb_pkg::job_t                mem_q [ltmb_pkg::QUEUE_DEPTH];
	logic [ltmb_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [ltmb_pkg::QPTR_W:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (ltmb_pkg::QPTR_W+1)'(push) - (ltmb_pkg::QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	assign pop_job   = mem_q[rd_q];
	assign not_empty = (count_q != '0);
	// room left for the two words that may already be in the front
	assign nearly_full = (count_q >= (ltmb_pkg::QPTR_W+1)'(ltmb_pkg::QUEUE_DEPTH - 2));

	`LTMB_ASSERT_IMP(a_no_overflow, clk, arst_n,
		count_q == (ltmb_pkg::QPTR_W+1)'(ltmb_pkg::QUEUE_DEPTH), !push || pop)

endmodule

// ===== hdl/ltmb_back.sv =====
// ----------------------------------------------------------------------------
// ltmb_back
// Blend arithmetic: weighted sum, pipelined rounding divider, scale and
// saturation. Takes one queue word per cycle and never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "layer_thickness_map_blend_defines.svh"

module ltmb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  ltmb_pkg::job_t            job,
	input  logic [15:0]               scale_factor,
	output logic                      done,
	output logic                      visible,
	output logic [ltmb_pkg::OUT_W-1:0] scaled_thickness
);

	localparam int DS = ltmb_pkg::DIV_STAGES;

	logic                         vld_s1, vis_s1, blend_s1;
	logic [ltmb_pkg::VAL_W-1:0]   h1_s1;
	logic [31:0]                  p1_s1, p2_s1;
	logic [ltmb_pkg::LEN_W-1:0]   len_s1;

	logic                         vld_s2, vis_s2;
	logic [ltmb_pkg::NUM_W-1:0]   num_s2;
	logic [ltmb_pkg::LEN_W-1:0]   len_s2;

	// divider stages, index 0 is the dividend setup from s2
	logic                         dvld_s [DS+1];
	logic                         dvis_s [DS+1];
	logic [ltmb_pkg::LEN_W-1:0]   drem_s [DS+1];
	logic [ltmb_pkg::VAL_W-1:0]   dlow_s [DS+1];
	logic [ltmb_pkg::LEN_W-1:0]   dlen_s [DS+1];
	logic [ltmb_pkg::VAL_W-1:0]   dq_s   [DS+1];

	logic                         vld_s3, vis_s3;
	logic [31:0]                  prod_s3;

	logic [32:0]                  rnd;
	logic [24:0]                  shr;

	logic                         done_q, visible_q;
	logic [ltmb_pkg::OUT_W-1:0]   scaled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= dvld_s[DS];
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		vis_s1   <= job.vis;
		blend_s1 <= job.blend;
		h1_s1    <= job.h1;
		p1_s1    <= job.h1 * job.far_dist;
		p2_s1    <= job.h2 * job.near_dist;
		len_s1   <= {1'b0, job.near_dist} + {1'b0, job.far_dist};

		vis_s2 <= vis_s1;
		// single sample goes through the divider as h1 / 1
		if (blend_s1) begin
			num_s2 <= ltmb_pkg::NUM_W'({1'b0, p1_s1} + {1'b0, p2_s1})
				+ ltmb_pkg::NUM_W'(len_s1 >> 1);
			len_s2 <= len_s1;
		end else begin
			num_s2 <= ltmb_pkg::NUM_W'(h1_s1);
			len_s2 <= ltmb_pkg::LEN_W'(1);
		end
	end

	// quotient fits VAL_W bits, so the top of the dividend is already below len
	assign dvld_s[0] = vld_s2;
	assign dvis_s[0] = vis_s2;
	assign drem_s[0] = num_s2[ltmb_pkg::NUM_W-1:ltmb_pkg::VAL_W];
	assign dlow_s[0] = num_s2[ltmb_pkg::VAL_W-1:0];
	assign dlen_s[0] = len_s2;
	assign dq_s[0]   = '0;

	for (genvar k = 0; k < DS; k++) begin : g_div
		logic [ltmb_pkg::LEN_W:0] trial;
		logic                     ge;
		assign trial = {drem_s[k], dlow_s[k][ltmb_pkg::VAL_W-1]};
		assign ge    = (trial >= {1'b0, dlen_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k+1] <= 1'b0;
			end else begin
				dvld_s[k+1] <= dvld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dvis_s[k+1] <= dvis_s[k];
			dlen_s[k+1] <= dlen_s[k];
			dlow_s[k+1] <= {dlow_s[k][ltmb_pkg::VAL_W-2:0], 1'b0};
			dq_s[k+1]   <= {dq_s[k][ltmb_pkg::VAL_W-2:0], ge};
			drem_s[k+1] <= ge ? ltmb_pkg::LEN_W'(trial - {1'b0, dlen_s[k]})
				: ltmb_pkg::LEN_W'(trial);
		end
	end

	always_ff @(posedge clk) begin
		vis_s3  <= dvis_s[DS];
		prod_s3 <= dq_s[DS] * scale_factor;
	end

	assign rnd = {1'b0, prod_s3} + 33'(ltmb_pkg::ROUND_HALF);
	assign shr = rnd[32:8];

	always_ff @(posedge clk) begin
		visible_q <= vis_s3;
		if (!vis_s3) begin
			scaled_q <= '0;
		end else if (shr > 25'(ltmb_pkg::OUT_MAX)) begin
			scaled_q <= ltmb_pkg::OUT_MAX;
		end else begin
			scaled_q <= shr[ltmb_pkg::OUT_W-1:0];
		end
	end

	assign done             = done_q;
	assign visible          = visible_q;
	assign scaled_thickness = scaled_q;

	`LTMB_ASSERT_IMP(a_hidden_is_zero, clk, arst_n, done_q && !visible_q, scaled_q == '0)
	`LTMB_ASSERT_NXT(a_div_feeds_out, clk, arst_n, dvld_s[DS], vld_s3)

endmodule

// ===== hdl/layer_thickness_map_blend.sv =====
// ----------------------------------------------------------------------------
// layer_thickness_map_blend
// Layer thickness table with two-sample inverse distance blending.
//
//   channel   | handshake            | words
//   ----------+----------------------+-------------------------------------
//   command   | start / busy         | load or query, one per cycle
//   result    | done strobe          | visible, scaled_thickness per query
//   config    | APB psel/penable     | blend_mode, scale_factor, cols, rows
//
// One item per cycle while busy is low. A query's result passes through
// 2 front stages with the table read, queue, 2 sum stages, 16 divider
// stages, scale and round. Loads give no result.
// After reset the table's 262144 entries are cleared one entry a cycle,
// with busy high. The result side has no backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module layer_thickness_map_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] first_boundary,
	input  logic        first_boundary_valid,
	input  logic [15:0] second_boundary,
	input  logic        second_boundary_valid,
	input  logic        pixel_known,
	input  logic [9:0]  near_col,
	input  logic [9:0]  near_row,
	input  logic [15:0] near_dist,
	input  logic [9:0]  far_col,
	input  logic [9:0]  far_row,
	input  logic [15:0] far_dist,
	output logic        done,
	output logic        visible,
	output logic [23:0] scaled_thickness,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ltmb_pkg::cfg_t     cfg_q;
	ltmb_pkg::reg_idx_t reg_sel;
	ltmb_pkg::job_t     push_job, pop_job;
	logic               accept, clearing, push, not_empty, nearly_full;

	assign reg_sel = ltmb_pkg::reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend_mode   <= 1'b0;
			cfg_q.scale_factor <= 16'd256;
			cfg_q.cols_in_use  <= '0;
			cfg_q.rows_in_use  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				ltmb_pkg::REG_BLEND_MODE:   cfg_q.blend_mode   <= pwdata[0];
				ltmb_pkg::REG_SCALE_FACTOR: cfg_q.scale_factor <= pwdata[15:0];
				ltmb_pkg::REG_COLS_IN_USE:  cfg_q.cols_in_use  <= pwdata[10:0];
				ltmb_pkg::REG_ROWS_IN_USE:  cfg_q.rows_in_use  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ltmb_pkg::REG_BLEND_MODE:   prdata = {31'b0, cfg_q.blend_mode};
			ltmb_pkg::REG_SCALE_FACTOR: prdata = {16'b0, cfg_q.scale_factor};
			ltmb_pkg::REG_COLS_IN_USE:  prdata = {21'b0, cfg_q.cols_in_use};
			ltmb_pkg::REG_ROWS_IN_USE:  prdata = {23'b0, cfg_q.rows_in_use};
			default:                    prdata = '0;
		endcase
	end

	assign busy   = clearing || nearly_full;
	assign accept = start && !busy;

	ltmb_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.accept               (accept),
		.cfg                  (cfg_q),
		.action               (action),
		.first_boundary       (first_boundary),
		.first_boundary_valid (first_boundary_valid),
		.second_boundary      (second_boundary),
		.second_boundary_valid(second_boundary_valid),
		.pixel_known          (pixel_known),
		.near_col             (near_col),
		.near_row             (near_row),
		.near_dist            (near_dist),
		.far_col              (far_col),
		.far_row              (far_row),
		.far_dist             (far_dist),
		.clearing             (clearing),
		.push                 (push),
		.job                  (push_job)
	);

	ltmb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (not_empty),
		.pop_job    (pop_job),
		.not_empty  (not_empty),
		.nearly_full(nearly_full)
	);

	ltmb_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (not_empty),
		.job             (pop_job),
		.scale_factor    (cfg_q.scale_factor),
		.done            (done),
		.visible         (visible),
		.scaled_thickness(scaled_thickness)
	);

endmodule
